// ===== rtl/alarm_clock_mode_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alarm clock mode controller
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_MODE_CONTROLLER_CORE_ASSERT_SVH
`define ALARM_CLOCK_MODE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication: ante |-> cons
`define ACMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: ante |=> cons
`define ACMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/acmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_pkg
// Request codes, mode codes, stage payload types and BCD helpers shared by
// the alarm clock mode controller modules.
// ----------------------------------------------------------------------------
package acmc_pkg;

  // Request codes
  localparam logic [2:0] REQ_SAMPLE = 3'd0;
  localparam logic [2:0] REQ_SET    = 3'd1;
  localparam logic [2:0] REQ_INC    = 3'd2;
  localparam logic [2:0] REQ_NEXT   = 3'd3;
  localparam logic [2:0] REQ_ALARM  = 3'd4;

  // Mode codes
  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_SET_TIME  = 2'd1;
  localparam logic [1:0] MODE_SET_ALARM = 2'd2;

  // Field select codes
  localparam logic FIELD_HOUR   = 1'b0;
  localparam logic FIELD_MINUTE = 1'b1;

  // Constants
  localparam logic [7:0] SEC_MASK       = 8'h7F;
  localparam logic [7:0] HOUR_MASK      = 8'h3F;
  localparam logic [7:0] HOURS_PER_DAY  = 8'd24;
  localparam logic [7:0] MIN_PER_HOUR   = 8'd60;
  localparam logic [7:0] ALARM_HOUR_RST = 8'd12;
  localparam logic [7:0] ALARM_MIN_RST  = 8'd54;

  // Widths of the stream buses
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 72;

  // One accepted request
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] sample_sec_bcd;
    logic [7:0] sample_min_bcd;
    logic [7:0] sample_hour_bcd;
  } item_t;

  // One result
  typedef struct packed {
    logic [1:0] cur_mode;
    logic       edit_field_sel;
    logic [7:0] edit_hour_val;
    logic [7:0] edit_minute_val;
    logic [7:0] alarm_hour_val;
    logic [7:0] alarm_minute_val;
    logic [7:0] now_hour;
    logic [7:0] now_minute;
    logic       ring_pulse;
    logic       rtc_write_valid;
    logic [7:0] write_hour_bcd;
    logic [7:0] write_minute_bcd;
  } result_t;

  // Two BCD digits to binary, digits not checked (0..165)
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // Binary to BCD, tens digit kept to four bits.
  // Quotient by 10 as (v * 205) >> 11, exact for all 8-bit values.
  function automatic logic [7:0] bcd_encode(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = {8'd0, v} * 16'd205;
    quo  = prod[15:11];
    rem  = v - ({3'd0, quo} * 8'd10);
    return {quo[3:0], rem[3:0]};
  endfunction

endpackage

// ===== rtl/acmc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_in_stage
// Input register: captures one request and holds it until the update stage
// takes it.
// ----------------------------------------------------------------------------
module acmc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  acmc_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output acmc_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  acmc_pkg::item_t item_r;

  // Accept when empty or when the held request moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/acmc_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_update
// Controller state and its update: mode, edit field, edit time,
// clock time, alarm time and ring latch. Builds the result of each request.
// ----------------------------------------------------------------------------
module acmc_update (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  acmc_pkg::item_t   item,
  output acmc_pkg::result_t result
);

  logic [1:0] mode_r,         mode_nxt;
  logic       field_r,        field_nxt;
  logic [7:0] edit_hour_r,    edit_hour_nxt;
  logic [7:0] edit_minute_r,  edit_minute_nxt;
  logic [7:0] clock_hour_r,   clock_hour_nxt;
  logic [7:0] clock_minute_r, clock_minute_nxt;
  logic [7:0] alarm_hour_r,   alarm_hour_nxt;
  logic [7:0] alarm_minute_r, alarm_minute_nxt;
  logic       ring_r,         ring_nxt;

  logic       editing;
  logic [7:0] dec_sec;
  logic [7:0] dec_min;
  logic [7:0] dec_hour;
  logic [8:0] hour_inc;
  logic [8:0] hour_wrap;
  logic [8:0] min_inc;
  logic [8:0] min_wrap1;
  logic [8:0] min_wrap2;
  logic       ring_pulse;
  logic       wr_valid;

  assign editing = (mode_r == acmc_pkg::MODE_SET_TIME) ||
                   (mode_r == acmc_pkg::MODE_SET_ALARM);

  // Decode the sample bytes
  assign dec_sec  = acmc_pkg::bcd_decode(item.sample_sec_bcd & acmc_pkg::SEC_MASK);
  assign dec_min  = acmc_pkg::bcd_decode(item.sample_min_bcd);
  assign dec_hour = acmc_pkg::bcd_decode(item.sample_hour_bcd & acmc_pkg::HOUR_MASK);

  // Wrap the incremented hour; held hours stay below 46, one subtract does it
  assign hour_inc  = {1'b0, edit_hour_r} + 9'd1;
  assign hour_wrap = (hour_inc >= {1'b0, acmc_pkg::HOURS_PER_DAY}) ?
                     hour_inc - {1'b0, acmc_pkg::HOURS_PER_DAY} : hour_inc;

  // Wrap the incremented minute; held minutes stay below 166, two subtracts
  assign min_inc   = {1'b0, edit_minute_r} + 9'd1;
  assign min_wrap1 = (min_inc >= {1'b0, acmc_pkg::MIN_PER_HOUR}) ?
                     min_inc - {1'b0, acmc_pkg::MIN_PER_HOUR} : min_inc;
  assign min_wrap2 = (min_wrap1 >= {1'b0, acmc_pkg::MIN_PER_HOUR}) ?
                     min_wrap1 - {1'b0, acmc_pkg::MIN_PER_HOUR} : min_wrap1;

  // Next state and per-request flags
  always_comb begin
    mode_nxt         = mode_r;
    field_nxt        = field_r;
    edit_hour_nxt    = edit_hour_r;
    edit_minute_nxt  = edit_minute_r;
    clock_hour_nxt   = clock_hour_r;
    clock_minute_nxt = clock_minute_r;
    alarm_hour_nxt   = alarm_hour_r;
    alarm_minute_nxt = alarm_minute_r;
    ring_nxt         = ring_r;
    ring_pulse       = 1'b0;
    wr_valid         = 1'b0;
    unique case (item.req_type)
      acmc_pkg::REQ_SAMPLE: begin
        if (mode_r == acmc_pkg::MODE_NORMAL) begin
          clock_hour_nxt   = dec_hour;
          clock_minute_nxt = dec_min;
          // Ring once at the alarm minute on second zero
          if ((dec_hour == alarm_hour_r) && (dec_min == alarm_minute_r) &&
              (dec_sec == 8'd0) && !ring_r) begin
            ring_nxt   = 1'b1;
            ring_pulse = 1'b1;
          end
          // Re-arm once the minute moves off the alarm
          if (dec_min != alarm_minute_r) begin
            ring_nxt = 1'b0;
          end
        end
      end
      acmc_pkg::REQ_SET: begin
        unique case (mode_r)
          acmc_pkg::MODE_NORMAL: begin
            mode_nxt        = acmc_pkg::MODE_SET_TIME;
            edit_hour_nxt   = clock_hour_r;
            edit_minute_nxt = clock_minute_r;
            field_nxt       = acmc_pkg::FIELD_HOUR;
          end
          acmc_pkg::MODE_SET_TIME: begin
            wr_valid = 1'b1;
            mode_nxt = acmc_pkg::MODE_NORMAL;
          end
          acmc_pkg::MODE_SET_ALARM: begin
            alarm_hour_nxt   = edit_hour_r;
            alarm_minute_nxt = edit_minute_r;
            mode_nxt         = acmc_pkg::MODE_NORMAL;
          end
          default: begin
            mode_nxt = mode_r;
          end
        endcase
      end
      acmc_pkg::REQ_INC: begin
        if (editing) begin
          if (field_r == acmc_pkg::FIELD_HOUR) begin
            edit_hour_nxt = hour_wrap[7:0];
          end else begin
            edit_minute_nxt = min_wrap2[7:0];
          end
        end
      end
      acmc_pkg::REQ_NEXT: begin
        if (editing) begin
          field_nxt = ~field_r;
        end
      end
      acmc_pkg::REQ_ALARM: begin
        if (mode_r == acmc_pkg::MODE_NORMAL) begin
          mode_nxt        = acmc_pkg::MODE_SET_ALARM;
          edit_hour_nxt   = alarm_hour_r;
          edit_minute_nxt = alarm_minute_r;
          field_nxt       = acmc_pkg::FIELD_HOUR;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  // Commit state when a request goes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= acmc_pkg::MODE_NORMAL;
      field_r        <= acmc_pkg::FIELD_HOUR;
      edit_hour_r    <= 8'd0;
      edit_minute_r  <= 8'd0;
      clock_hour_r   <= 8'd0;
      clock_minute_r <= 8'd0;
      alarm_hour_r   <= acmc_pkg::ALARM_HOUR_RST;
      alarm_minute_r <= acmc_pkg::ALARM_MIN_RST;
      ring_r         <= 1'b0;
    end else if (fire) begin
      mode_r         <= mode_nxt;
      field_r        <= field_nxt;
      edit_hour_r    <= edit_hour_nxt;
      edit_minute_r  <= edit_minute_nxt;
      clock_hour_r   <= clock_hour_nxt;
      clock_minute_r <= clock_minute_nxt;
      alarm_hour_r   <= alarm_hour_nxt;
      alarm_minute_r <= alarm_minute_nxt;
      ring_r         <= ring_nxt;
    end
  end

  // Result reports the state after the request
  always_comb begin
    result.cur_mode         = mode_nxt;
    result.edit_field_sel   = field_nxt;
    result.edit_hour_val    = edit_hour_nxt;
    result.edit_minute_val  = edit_minute_nxt;
    result.alarm_hour_val   = alarm_hour_nxt;
    result.alarm_minute_val = alarm_minute_nxt;
    result.now_hour         = clock_hour_nxt;
    result.now_minute       = clock_minute_nxt;
    result.ring_pulse       = ring_pulse;
    result.rtc_write_valid  = wr_valid;
    result.write_hour_bcd   = wr_valid ? acmc_pkg::bcd_encode(edit_hour_r) : 8'd0;
    result.write_minute_bcd = wr_valid ? acmc_pkg::bcd_encode(edit_minute_r) : 8'd0;
  end

endmodule

// ===== rtl/acmc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module acmc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  acmc_pkg::result_t res_in,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output acmc_pkg::result_t res_out
);

  logic              valid_r;
  logic              valid_nxt;
  acmc_pkg::result_t res_r;

  // Room when empty or when the held result drains this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = can_load ? load : valid_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture result
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== rtl/alarm_clock_mode_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_mode_controller_core
// Alarm clock mode controller: RTC samples and button presses in, one status
// result per request out (mode, edit time, alarm, clock, ring, RTC write).
//
//   Channel   Direction  Ports                          Payload
//   in_       slave      in_tvalid/in_tready            in_tuser, in_tdata
//   out_      master     out_tvalid/out_tready          out_tdata
//
// One request per cycle sustained while out_tready is high; a request goes
// through the input register, update logic and result register to out_tvalid.
// Reset: synchronous rst_n low clears both stages and loads the state with
// normal mode, zero times and alarm 12:54.
// A stalled out_tready holds the result; the input register still takes one
// more request, then in_tready drops until the result drains.
// ----------------------------------------------------------------------------
`include "alarm_clock_mode_controller_core_assert.svh"

module alarm_clock_mode_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] req_type
  input  logic [2:0]  in_tuser,
  // [7:0] sample_sec_bcd, [15:8] sample_min_bcd, [23:16] sample_hour_bcd
  input  logic [23:0] in_tdata,
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] cur_mode, [2] edit_field_sel, [10:3] edit_hour_val,
  // [18:11] edit_minute_val, [26:19] alarm_hour_val, [34:27] alarm_minute_val,
  // [42:35] now_hour, [50:43] now_minute, [51] ring_pulse,
  // [52] rtc_write_valid, [60:53] write_hour_bcd, [68:61] write_minute_bcd,
  // [71:69] zero
  output logic [71:0] out_tdata
);

  acmc_pkg::item_t   in_item;
  acmc_pkg::item_t   s1_item;
  logic              s1_valid;
  logic              can_load;
  logic              fire;
  acmc_pkg::result_t upd_res;
  acmc_pkg::result_t out_res;

  // Unpack the request
  always_comb begin
    in_item.req_type        = in_tuser;
    in_item.sample_sec_bcd  = in_tdata[7:0];
    in_item.sample_min_bcd  = in_tdata[15:8];
    in_item.sample_hour_bcd = in_tdata[23:16];
  end

  // Advance when a request is held and the result register has room
  assign fire = s1_valid && can_load;

  acmc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (fire),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  acmc_update u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item),
    .result (upd_res)
  );

  acmc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_in    (upd_res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (out_res)
  );

  // Pack the result
  assign out_tdata = {3'd0,
                      out_res.write_minute_bcd,
                      out_res.write_hour_bcd,
                      out_res.rtc_write_valid,
                      out_res.ring_pulse,
                      out_res.now_minute,
                      out_res.now_hour,
                      out_res.alarm_minute_val,
                      out_res.alarm_hour_val,
                      out_res.edit_minute_val,
                      out_res.edit_hour_val,
                      out_res.edit_field_sel,
                      out_res.cur_mode};

  // An RTC write always lands back in normal mode
  `ACMC_ASSERT_NOW(a_write_in_normal, out_tvalid && out_res.rtc_write_valid, out_res.cur_mode == acmc_pkg::MODE_NORMAL, "RTC write outside normal mode")

  // A ring only fires when the clock matches the alarm
  `ACMC_ASSERT_NOW(a_ring_on_match, out_tvalid && out_res.ring_pulse, (out_res.now_hour == out_res.alarm_hour_val) && (out_res.now_minute == out_res.alarm_minute_val), "ring without alarm match")

  // A request moved into the result register shows up next cycle
  `ACMC_ASSERT_NEXT(a_fire_to_out, fire, out_tvalid, "result lost after update")

  // Write data stays zero without a write
  `ACMC_ASSERT_NOW(a_write_data_zero, out_tvalid && !out_res.rtc_write_valid, (out_res.write_hour_bcd == 8'd0) && (out_res.write_minute_bcd == 8'd0), "write data without write")

endmodule
